/* sv/stkc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package stkc_pkg;

  localparam int WORD_W  = 32;
  localparam int CMD_W   = 5;
  localparam int DEPTH_W = 6;
  localparam int FAULT_W = 2;

  localparam int DEFAULT_STACK_DEPTH = 32;

  localparam logic [WORD_W-1:0] RAM_PLUS_INC = 32'h1000_0000;

  localparam logic [CMD_W-1:0] OP_PUSH      = 5'd0;
  localparam logic [CMD_W-1:0] OP_ADD       = 5'd1;
  localparam logic [CMD_W-1:0] OP_SUB       = 5'd2;
  localparam logic [CMD_W-1:0] OP_MUL       = 5'd3;
  localparam logic [CMD_W-1:0] OP_DIV       = 5'd4;
  localparam logic [CMD_W-1:0] OP_MOD       = 5'd5;
  localparam logic [CMD_W-1:0] OP_NEG       = 5'd6;
  localparam logic [CMD_W-1:0] OP_DUP       = 5'd7;
  localparam logic [CMD_W-1:0] OP_DISCARD   = 5'd8;
  localparam logic [CMD_W-1:0] OP_EXCH      = 5'd9;
  localparam logic [CMD_W-1:0] OP_COPY_NEXT = 5'd10;
  localparam logic [CMD_W-1:0] OP_NOT       = 5'd11;
  localparam logic [CMD_W-1:0] OP_AND       = 5'd12;
  localparam logic [CMD_W-1:0] OP_OR        = 5'd13;
  localparam logic [CMD_W-1:0] OP_XOR       = 5'd14;
  localparam logic [CMD_W-1:0] OP_SHL       = 5'd15;
  localparam logic [CMD_W-1:0] OP_SHR       = 5'd16;
  localparam logic [CMD_W-1:0] OP_SAR       = 5'd17;
  localparam logic [CMD_W-1:0] OP_DOT       = 5'd18;
  localparam logic [CMD_W-1:0] OP_ADD_HIGH  = 5'd19;

  localparam logic [FAULT_W-1:0] FAULT_NONE  = 2'd0;
  localparam logic [FAULT_W-1:0] FAULT_OVER  = 2'd1;
  localparam logic [FAULT_W-1:0] FAULT_UNDER = 2'd2;
  localparam logic [FAULT_W-1:0] FAULT_DIVZ  = 2'd3;

  typedef struct packed {
    logic shift_dn;
    logic shift_up;
  } cell_ctl_t;

endpackage

`default_nettype wire

/* sv/stkc_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface stkc_in_if import stkc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic signed [WORD_W-1:0] literal;

  modport source (output valid, output cmd, output literal, input ready);
  modport sink (input valid, input cmd, input literal, output ready);
endinterface

interface stkc_out_if import stkc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] top_value;
  logic [DEPTH_W-1:0]       stack_depth;
  logic signed [WORD_W-1:0] printed_value;
  logic                     printed_valid;
  logic [FAULT_W-1:0]       fault;

  modport source (output valid, output top_value, output stack_depth,
                  output printed_value, output printed_valid, output fault,
                  input ready);
  modport sink (input valid, input top_value, input stack_depth,
                input printed_value, input printed_valid, input fault,
                output ready);
endinterface

`default_nettype wire

/* sv/stkc_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module stkc_cell import stkc_pkg::*; (
  input  wire logic              clk,
  input  wire cell_ctl_t         ctl,
  input  wire logic [WORD_W-1:0] up_data,
  input  wire logic [WORD_W-1:0] dn_data,
  output logic      [WORD_W-1:0] q
);

  logic [WORD_W-1:0] word_r;

  always_ff @(posedge clk) begin
    if (ctl.shift_dn) begin
      word_r <= up_data;
    end else if (ctl.shift_up) begin
      word_r <= dn_data;
    end
  end

  assign q = word_r;

endmodule

`default_nettype wire

/* sv/stkc_div.sv */
`timescale 1ns / 1ps
`default_nettype none

module stkc_div import stkc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [WORD_W-1:0] dividend,
  input  wire logic [WORD_W-1:0] divisor,
  output logic                   done,
  output logic      [WORD_W-1:0] quotient,
  output logic      [WORD_W-1:0] remainder
);

  localparam int STEP_W = $clog2(WORD_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [WORD_W-1:0] rem_r, rem_nxt;
  logic [WORD_W-1:0] quo_r, quo_nxt;
  logic [WORD_W-1:0] dvs_r, dvs_nxt;
  logic [WORD_W:0]   trial;

  // The partial remainder stays below the divisor, which is at most 2^31, so the
  // shifted remainder fits in one word.
  assign trial = {1'b0, rem_r[WORD_W-2:0], quo_r[WORD_W-1]} - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (!trial[WORD_W]) begin
        rem_nxt = trial[WORD_W-1:0];
      end else begin
        rem_nxt = {rem_r[WORD_W-2:0], quo_r[WORD_W-1]};
      end
      quo_nxt  = {quo_r[WORD_W-2:0], ~trial[WORD_W]};
      step_nxt = step_r + STEP_W'(1);
      if (step_r == STEP_W'(WORD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

/* sv/stack_calculator_core_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Forth-style data stack with a cached top word and a 32-bit integer ALU. Each input
// transaction is one stack word and yields exactly one result transaction carrying
// the new top, the depth, an optional printed value from dot, and a fault code; a
// faulting word leaves the stack untouched. The words below the top live in a chain
// of STACK_DEPTH-1 cells that shift down on a push and up on a pop. Div and mod run on
// the restoring divider, which produces one quotient bit per cycle, and block new
// transactions until it finishes; every other word completes when it is accepted. A
// new transaction is accepted while the previous result is being taken. The cells
// have no reset, and no clearing pass is needed.
module stack_calculator_core_top import stkc_pkg::*; #(
  parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
  input wire logic   clk,
  input wire logic   rst_n,
  stkc_in_if.sink    in_if,
  stkc_out_if.source out_if
);

  localparam int CELLS = STACK_DEPTH - 1;
  localparam int CW    = $clog2(STACK_DEPTH + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DIV  = 1'b1;

  logic               state_r, state_nxt;
  logic [WORD_W-1:0]  top_r, top_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic               is_mod_r, is_mod_nxt;
  logic               neg_q_r, neg_q_nxt;
  logic               neg_r_r, neg_r_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]  out_top_r, out_top_nxt;
  logic [DEPTH_W-1:0] out_depth_r, out_depth_nxt;
  logic [WORD_W-1:0]  out_print_r, out_print_nxt;
  logic               out_pvalid_r, out_pvalid_nxt;
  logic [FAULT_W-1:0] out_fault_r, out_fault_nxt;

  logic [WORD_W-1:0]  cell_q [CELLS];
  cell_ctl_t          cell_ctl [CELLS];
  logic               shift_dn, shift_up, swap_top;

  logic               in_fire;
  logic               div_start, div_done;
  logic [WORD_W-1:0]  div_q, div_r;
  logic [WORD_W-1:0]  sec, tw;
  logic [WORD_W-1:0]  mag_a, mag_b;
  logic [WORD_W-1:0]  alu_res;
  logic               big_shift;
  logic               has1, has2, full;
  logic [FAULT_W-1:0] fault;
  logic [WORD_W-1:0]  printed;
  logic               pvalid;

  assign in_if.ready = (state_r == ST_IDLE) && (!out_valid_r || out_if.ready);
  assign in_fire     = in_if.valid && in_if.ready;

  assign sec  = cell_q[0];
  assign tw   = top_r;
  assign has1 = (count_r != '0);
  assign has2 = (count_r >= CW'(2));
  assign full = (count_r == CW'(STACK_DEPTH));

  assign mag_a     = sec[WORD_W-1] ? (~sec + WORD_W'(1)) : sec;
  assign mag_b     = tw[WORD_W-1] ? (~tw + WORD_W'(1)) : tw;
  assign big_shift = |tw[WORD_W-1:5];

  always_comb begin
    case (in_if.cmd)
      OP_ADD: alu_res = sec + tw;
      OP_SUB: alu_res = sec - tw;
      OP_MUL: alu_res = sec * tw;
      OP_AND: alu_res = sec & tw;
      OP_OR:  alu_res = sec | tw;
      OP_XOR: alu_res = sec ^ tw;
      OP_SHL: alu_res = big_shift ? '0 : (sec << tw[4:0]);
      OP_SHR: alu_res = big_shift ? '0 : (sec >> tw[4:0]);
      OP_SAR: alu_res = big_shift ? {WORD_W{sec[WORD_W-1]}}
                                  : WORD_W'($signed(sec) >>> tw[4:0]);
      default: alu_res = '0;
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    top_nxt    = top_r;
    count_nxt  = count_r;
    is_mod_nxt = is_mod_r;
    neg_q_nxt  = neg_q_r;
    neg_r_nxt  = neg_r_r;
    shift_dn   = 1'b0;
    shift_up   = 1'b0;
    swap_top   = 1'b0;
    div_start  = 1'b0;
    fault      = FAULT_NONE;
    printed    = '0;
    pvalid     = 1'b0;

    if (in_fire) begin
      unique case (in_if.cmd) inside
        OP_PUSH: begin
          if (full) begin
            fault = FAULT_OVER;
          end else begin
            shift_dn  = 1'b1;
            top_nxt   = in_if.literal;
            count_nxt = count_r + CW'(1);
          end
        end
        OP_DIV, OP_MOD: begin
          if (!has2) begin
            fault = FAULT_UNDER;
          end else if (tw == '0) begin
            fault = FAULT_DIVZ;
          end else begin
            div_start  = 1'b1;
            state_nxt  = ST_DIV;
            is_mod_nxt = (in_if.cmd == OP_MOD);
            neg_q_nxt  = sec[WORD_W-1] ^ tw[WORD_W-1];
            neg_r_nxt  = sec[WORD_W-1];
          end
        end
        OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_OR, OP_XOR,
        OP_SHL, OP_SHR, OP_SAR: begin
          if (!has2) begin
            fault = FAULT_UNDER;
          end else begin
            shift_up  = 1'b1;
            top_nxt   = alu_res;
            count_nxt = count_r - CW'(1);
          end
        end
        OP_NEG, OP_NOT, OP_ADD_HIGH: begin
          if (!has1) begin
            fault = FAULT_UNDER;
          end else if (in_if.cmd == OP_NEG) begin
            top_nxt = ~tw + WORD_W'(1);
          end else if (in_if.cmd == OP_NOT) begin
            top_nxt = ~tw;
          end else begin
            top_nxt = tw + RAM_PLUS_INC;
          end
        end
        OP_DUP: begin
          if (!has1) begin
            fault = FAULT_UNDER;
          end else if (full) begin
            fault = FAULT_OVER;
          end else begin
            shift_dn  = 1'b1;
            count_nxt = count_r + CW'(1);
          end
        end
        OP_DISCARD, OP_DOT: begin
          if (!has1) begin
            fault = FAULT_UNDER;
          end else begin
            shift_up  = 1'b1;
            top_nxt   = has2 ? sec : '0;
            count_nxt = count_r - CW'(1);
            if (in_if.cmd == OP_DOT) begin
              printed = tw;
              pvalid  = 1'b1;
            end
          end
        end
        OP_EXCH: begin
          if (!has2) begin
            fault = FAULT_UNDER;
          end else begin
            swap_top = 1'b1;
            top_nxt  = sec;
          end
        end
        OP_COPY_NEXT: begin
          if (!has2) begin
            fault = FAULT_UNDER;
          end else if (full) begin
            fault = FAULT_OVER;
          end else begin
            shift_dn  = 1'b1;
            top_nxt   = sec;
            count_nxt = count_r + CW'(1);
          end
        end
        default: begin
        end
      endcase
    end else if (div_done) begin
      state_nxt = ST_IDLE;
      shift_up  = 1'b1;
      count_nxt = count_r - CW'(1);
      if (is_mod_r) begin
        top_nxt = neg_r_r ? (~div_r + WORD_W'(1)) : div_r;
      end else begin
        top_nxt = neg_q_r ? (~div_q + WORD_W'(1)) : div_q;
      end
    end
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_top_nxt    = out_top_r;
    out_depth_nxt  = out_depth_r;
    out_print_nxt  = out_print_r;
    out_pvalid_nxt = out_pvalid_r;
    out_fault_nxt  = out_fault_r;
    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
    if ((in_fire && !div_start) || div_done) begin
      out_valid_nxt  = 1'b1;
      out_top_nxt    = top_nxt;
      out_depth_nxt  = DEPTH_W'(count_nxt);
      out_print_nxt  = printed;
      out_pvalid_nxt = pvalid;
      out_fault_nxt  = fault;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      top_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      top_r       <= top_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    is_mod_r     <= is_mod_nxt;
    neg_q_r      <= neg_q_nxt;
    neg_r_r      <= neg_r_nxt;
    out_top_r    <= out_top_nxt;
    out_depth_r  <= out_depth_nxt;
    out_print_r  <= out_print_nxt;
    out_pvalid_r <= out_pvalid_nxt;
    out_fault_r  <= out_fault_nxt;
  end

  genvar k;
  generate
    for (k = 0; k < CELLS; k++) begin : g_cell
      logic [WORD_W-1:0] up_data;
      logic [WORD_W-1:0] dn_data;

      if (k == 0) begin : g_first
        assign up_data = top_r;
      end else begin : g_mid
        assign up_data = cell_q[k-1];
      end

      if (k == CELLS - 1) begin : g_last
        assign dn_data = cell_q[k];
      end else begin : g_inner
        assign dn_data = cell_q[k+1];
      end

      assign cell_ctl[k].shift_dn = shift_dn || (swap_top && (k == 0));
      assign cell_ctl[k].shift_up = shift_up;

      stkc_cell u_cell (
        .clk     (clk),
        .ctl     (cell_ctl[k]),
        .up_data (up_data),
        .dn_data (dn_data),
        .q       (cell_q[k])
      );
    end
  endgenerate

  stkc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (mag_a),
    .divisor   (mag_b),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  assign out_if.valid         = out_valid_r;
  assign out_if.top_value     = out_top_r;
  assign out_if.stack_depth   = out_depth_r;
  assign out_if.printed_value = out_print_r;
  assign out_if.printed_valid = out_pvalid_r;
  assign out_if.fault         = out_fault_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(STACK_DEPTH))
    else $error("stack count exceeds the stack depth");

  a_div_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> !out_valid_r)
    else $error("result pending while a division runs");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("divider finished outside a division");

  a_div_start_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> (state_r == ST_DIV) && !in_if.ready)
    else $error("division start did not block new transactions");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !div_start) |=> out_valid_r)
    else $error("accepted transaction produced no result");

endmodule

`default_nettype wire
